>>> rtl/core/ssmf_pkg.sv
// Shared constants and types for the stereo sliding median filter.
// No dependencies; compiled first.
`default_nettype none

package ssmf_pkg;

   // Width of the magnitude fields on the channels
   localparam int MAG_BITS = 16;

   // Defaults for the top-level parameters
   localparam int WINDOW_DEF      = 17;
   localparam int SAMPLE_BITS_DEF = 16;

   // Flags a cell hands to its right neighbor
   typedef struct packed {
      logic gt;        // this cell's value is above the incoming sample
      logic del_left;  // the oldest entry sits in this cell or further left
   } flags_type;

endpackage : ssmf_pkg

`default_nettype wire

>>> rtl/core/ssmf_req_if.sv
// Input channel of the stereo sliding median filter: valid/ready plus payload.
// Depends on ssmf_pkg.
`default_nettype none

interface ssmf_req_if;
   import ssmf_pkg::*;

   logic                valid;
   logic                ready;
   logic [MAG_BITS-1:0] left_mag;
   logic [MAG_BITS-1:0] right_mag;
   logic                line_start;

   modport source (output valid, output left_mag, output right_mag, output line_start,
                   input ready);
   modport sink   (input valid, input left_mag, input right_mag, input line_start,
                   output ready);
endinterface : ssmf_req_if

`default_nettype wire

>>> rtl/core/ssmf_rsp_if.sv
// Result channel of the stereo sliding median filter: valid/ready plus payload.
// Depends on ssmf_pkg.
`default_nettype none

interface ssmf_rsp_if;
   import ssmf_pkg::*;

   logic                valid;
   logic                ready;
   logic [MAG_BITS-1:0] left_median;
   logic [MAG_BITS-1:0] right_median;
   logic                window_full;

   modport source (output valid, output left_median, output right_median,
                   output window_full, input ready);
   modport sink   (input valid, input left_median, input right_median,
                   input window_full, output ready);
endinterface : ssmf_rsp_if

`default_nettype wire

>>> rtl/core/ssmf_cell.sv
// One cell of the sorted window: holds one sample and its age, and takes its
// next value from itself, a neighbor or the new sample. Depends on ssmf_pkg.
`default_nettype none

module ssmf_cell #(
   parameter int WINDOW      = ssmf_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = ssmf_pkg::SAMPLE_BITS_DEF,
   parameter int INDEX       = 0,
   localparam int AGE_BITS   = $clog2(WINDOW)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   // left neighbor
   input  wire logic [SAMPLE_BITS-1:0] l_val,
   input  wire logic [AGE_BITS-1:0]    l_age,
   input  wire ssmf_pkg::flags_type    l_flags,
   // right neighbor
   input  wire logic [SAMPLE_BITS-1:0] r_val,
   input  wire logic [AGE_BITS-1:0]    r_age,
   input  wire logic                   r_gt,
   // to neighbors
   output      logic [SAMPLE_BITS-1:0] val,
   output      logic [AGE_BITS-1:0]    age,
   output      ssmf_pkg::flags_type    flags,
   output      logic [SAMPLE_BITS-1:0] val_next
);
   import ssmf_pkg::*;

   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic [AGE_BITS-1:0]    age_ff, age_in;
   logic                   oldest;
   logic                   del_here;
   logic                   take_lower;
   logic                   take_upper;

   // A line start looks like an all-zero window with ages by position.
   assign val = start ? '0 : val_ff;
   assign age = start ? AGE_BITS'(INDEX) : age_ff;

   assign oldest         = (age == AGE_BITS'(WINDOW - 1));
   assign del_here       = l_flags.del_left | oldest;
   assign flags.gt       = (val > sample);
   assign flags.del_left = del_here;

   // Slot sits below the insertion point / above it, after removing the oldest
   assign take_lower = del_here ? ~r_gt : ~flags.gt;
   assign take_upper = l_flags.del_left ? flags.gt : l_flags.gt;

   always_comb begin
      if (take_lower) begin
         val_in = del_here ? r_val : val;
         age_in = (del_here ? r_age : age) + AGE_BITS'(1);
      end else if (take_upper) begin
         val_in = l_flags.del_left ? val : l_val;
         age_in = (l_flags.del_left ? age : l_age) + AGE_BITS'(1);
      end else begin
         val_in = sample;
         age_in = '0;
      end
   end

   assign val_next = val_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= AGE_BITS'(INDEX);
      end else if (en) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule : ssmf_cell

`default_nettype wire

>>> rtl/core/ssmf_chain.sv
// Row of WINDOW cells keeping one channel's window sorted by value.
// Depends on ssmf_pkg and ssmf_cell.
`default_nettype none

module ssmf_chain #(
   parameter int WINDOW      = ssmf_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = ssmf_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output      logic [SAMPLE_BITS-1:0] median_next
);
   import ssmf_pkg::*;

   localparam int AGE_BITS = $clog2(WINDOW);
   localparam int MID      = WINDOW / 2;

   logic [SAMPLE_BITS-1:0] vals  [WINDOW];
   logic [AGE_BITS-1:0]    ages  [WINDOW];
   flags_type              flags [WINDOW];
   logic [SAMPLE_BITS-1:0] nexts [WINDOW];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] l_val, r_val;
      logic [AGE_BITS-1:0]    l_age, r_age;
      flags_type              l_flags;
      logic                   r_gt;

      if (i == 0) begin : g_first
         assign l_val   = '0;
         assign l_age   = '0;
         assign l_flags = '0;
      end else begin : g_mid_l
         assign l_val   = vals[i-1];
         assign l_age   = ages[i-1];
         assign l_flags = flags[i-1];
      end

      // Past the right end counts as above the sample
      if (i == WINDOW - 1) begin : g_last
         assign r_val = '0;
         assign r_age = '0;
         assign r_gt  = 1'b1;
      end else begin : g_mid_r
         assign r_val = vals[i+1];
         assign r_age = ages[i+1];
         assign r_gt  = flags[i+1].gt;
      end

      ssmf_cell #(
         .WINDOW      (WINDOW),
         .SAMPLE_BITS (SAMPLE_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .start    (start),
         .sample   (sample),
         .l_val    (l_val),
         .l_age    (l_age),
         .l_flags  (l_flags),
         .r_val    (r_val),
         .r_age    (r_age),
         .r_gt     (r_gt),
         .val      (vals[i]),
         .age      (ages[i]),
         .flags    (flags[i]),
         .val_next (nexts[i])
      );
   end

   assign median_next = nexts[MID];

endmodule : ssmf_chain

`default_nettype wire

>>> rtl/core/stereo_sliding_median_filter.sv
// Stereo sliding median filter: two sorted cell chains, fill counter and
// result register. Depends on ssmf_pkg, ssmf_req_if, ssmf_rsp_if, ssmf_chain.
//
// Usage:
//   req carries one left and one right magnitude per beat plus line_start,
//   which restarts both windows with this beat's sample. rsp returns one beat
//   per req beat: both channels' median of the last WINDOW samples of the line
//   and window_full; medians read 0 until WINDOW samples of the line are held.
//   Each channel keeps its window as a row of WINDOW cells sorted by value;
//   every accepted beat drops the oldest entry and inserts the new one,
//   the middle cell giving the median.
//   The result is valid the cycle after the req beat is accepted.
//   Throughput: one beat per cycle, except while a stall holds req.ready low.
//   Stall: the result register holds while rsp.ready is low; req.ready drops
//   only while a result waits and rsp.ready is low, so nothing is lost.
//   Reset (synchronous, active high) clears both windows, the fill count and
//   the result valid flag; the block takes a beat in the first cycle after it.
`default_nettype none

module stereo_sliding_median_filter #(
   parameter int WINDOW      = ssmf_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = ssmf_pkg::SAMPLE_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ssmf_req_if.sink req,
   ssmf_rsp_if.source rsp
);
   import ssmf_pkg::*;

   localparam int FILL_BITS = $clog2(WINDOW + 1);

   logic                         accept;
   logic [SAMPLE_BITS+MAG_BITS-1:0] left_ext, right_ext;
   logic [SAMPLE_BITS-1:0]       left_sample, right_sample;
   logic [SAMPLE_BITS-1:0]       left_med, right_med;
   logic [SAMPLE_BITS+MAG_BITS-1:0] left_med_ext, right_med_ext;
   logic [FILL_BITS-1:0]         fill_ff, fill_in;
   logic                         full_in;
   logic                         rsp_valid_ff;
   logic [MAG_BITS-1:0]          left_median_ff, left_median_in;
   logic [MAG_BITS-1:0]          right_median_ff, right_median_in;
   logic                         window_full_ff;

   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign accept    = req.valid & req.ready;

   // Fit channel magnitudes to the sample width
   assign left_ext     = {{SAMPLE_BITS{1'b0}}, req.left_mag};
   assign right_ext    = {{SAMPLE_BITS{1'b0}}, req.right_mag};
   assign left_sample  = left_ext[SAMPLE_BITS-1:0];
   assign right_sample = right_ext[SAMPLE_BITS-1:0];

   ssmf_chain #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left (
      .clock       (clock),
      .reset       (reset),
      .en          (accept),
      .start       (req.line_start),
      .sample      (left_sample),
      .median_next (left_med)
   );

   ssmf_chain #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right (
      .clock       (clock),
      .reset       (reset),
      .en          (accept),
      .start       (req.line_start),
      .sample      (right_sample),
      .median_next (right_med)
   );

   always_comb begin
      if (req.line_start) begin
         fill_in = FILL_BITS'(1);
      end else if (fill_ff == FILL_BITS'(WINDOW)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + FILL_BITS'(1);
      end
   end

   assign full_in = (fill_in == FILL_BITS'(WINDOW));

   assign left_med_ext    = {{MAG_BITS{1'b0}}, left_med};
   assign right_med_ext   = {{MAG_BITS{1'b0}}, right_med};
   assign left_median_in  = full_in ? left_med_ext[MAG_BITS-1:0] : '0;
   assign right_median_in = full_in ? right_med_ext[MAG_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_median_ff  <= left_median_in;
         right_median_ff <= right_median_in;
         window_full_ff  <= full_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.left_median  = left_median_ff;
   assign rsp.right_median = right_median_ff;
   assign rsp.window_full  = window_full_ff;

endmodule : stereo_sliding_median_filter

`default_nettype wire
